// ===== sv/tdf_pkg.sv =====
// shared constants and control types of the trial division factorizer
`timescale 1ns / 1ps

package tdf_pkg;

   localparam int VALUE_WIDTH_DEF = 31;
   localparam int MAX_RESULTS     = 31;
   localparam int SMALL_LIMIT     = 5;
   localparam int COUNT_W         = $clog2(MAX_RESULTS);

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic emit_small;
      logic emit_final;
      logic div_start;
      logic div_step;
      logic commit;
      logic advance;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_small;
      logic past_root;
      logic at_limit;
      logic div_done;
      logic rem_zero;
      logic quot_one;
   } dp_status_type;

endpackage

// ===== sv/tdf_datapath.sv =====
// datapath: cofactor, trial divisor, its square, bit-serial divider and result register
`timescale 1ns / 1ps

module tdf_datapath #(
   parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tdf_pkg::dp_cmd_type    cmd,
   output tdf_pkg::dp_status_type status,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_last
);
   import tdf_pkg::*;

   localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   sq_ff, sq_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_factor_ff, rsp_factor_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   // one restoring division step: bring down the next dividend bit
   assign trial = {rem_ff, acc_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   assign status.is_small  = (req_value <= VALUE_WIDTH'(SMALL_LIMIT));
   assign status.past_root = (sq_ff > {1'b0, quot_ff});
   assign status.at_limit  = (cnt_ff == COUNT_W'(MAX_RESULTS - 1));
   assign status.div_done  = (step_ff == '0);
   assign status.rem_zero  = (rem_ff == '0);
   assign status.quot_one  = (acc_ff == VALUE_WIDTH'(1));

   always_comb begin
      quot_in       = quot_ff;
      div_in        = div_ff;
      sq_in         = sq_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = rsp_factor_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load) begin
         quot_in = req_value;
         div_in  = VALUE_WIDTH'(2);
         sq_in   = (VALUE_WIDTH + 1)'(4);
         cnt_in  = '0;
      end
      if (cmd.emit_small) begin
         rsp_valid_in  = 1'b1;
         rsp_factor_in = req_value;
         rsp_last_in   = 1'b1;
      end
      if (cmd.emit_final) begin
         rsp_valid_in  = 1'b1;
         rsp_factor_in = quot_ff;
         rsp_last_in   = 1'b1;
      end
      if (cmd.div_start) begin
         acc_in  = quot_ff;
         rem_in  = '0;
         step_in = STEP_W'(VALUE_WIDTH);
      end
      if (cmd.div_step) begin
         acc_in  = {acc_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         step_in = step_ff - STEP_W'(1);
      end
      if (cmd.commit) begin
         quot_in       = acc_ff;
         cnt_in        = cnt_ff + COUNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_factor_in = div_ff;
         rsp_last_in   = status.quot_one;
      end
      if (cmd.advance) begin
         // (d+1)^2 = d^2 + 2d + 1
         div_in = div_ff + VALUE_WIDTH'(1);
         sq_in  = sq_ff + {div_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      quot_ff       <= quot_in;
      div_ff        <= div_in;
      sq_ff         <= sq_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_last   = rsp_last_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.commit || cmd.advance |-> rem_ff < div_ff)
      else $error("division remainder not below divisor");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> cnt_ff < COUNT_W'(MAX_RESULTS - 1))
      else $error("factor emitted past the result limit");

   a_advance_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !status.rem_zero && !cmd.commit)
      else $error("divisor advanced although it divides the cofactor");

endmodule

// ===== sv/tdf_ctrl.sv =====
// controller: sequences check, divide and resolve for each trial divisor
`timescale 1ns / 1ps

module tdf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output tdf_pkg::dp_cmd_type    cmd,
   input  tdf_pkg::dp_status_type status
);
   import tdf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESOLVE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.is_small) begin
                  cmd.emit_small = 1'b1;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // past the square root the cofactor is prime; at the result limit it is emitted as is
            if (status.past_root || status.at_limit) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_RESOLVE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_RESOLVE: begin
            if (status.rem_zero) begin
               cmd.commit = 1'b1;
               state_in   = status.quot_one ? ST_IDLE : ST_CHECK;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   a_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      busy == (state_ff != ST_IDLE))
      else $error("busy out of step with controller state");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE && start)
      else $error("load outside an accepted transfer");

   a_divide_then_resolve: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && status.div_done |=> state_ff == ST_RESOLVE)
      else $error("division finished without resolve");

endmodule

// ===== sv/trial_division_factorizer.sv =====
// top level of the trial division factorizer
// Usage: drive req_value and pulse start; the value is taken at a clock edge with
// start high and busy low. Prime factors then come out in ascending order, repeats
// included, one per rsp_valid strobe, each shown with rsp_valid high for one cycle;
// rsp_last marks the final factor. Values of 5 or less come back unchanged as one
// final result the cycle after the transfer, and busy stays low for them.
// Timing: each trial division is a bound check, then the bit-serial restoring
// divider, then a resolve step; a found factor costs the same and appears the
// cycle after its resolve step. All trial divisions run one after another on the
// shared divider; a prime input walks every divisor up to its square root.
// Busy drops in the cycle the final result is shown, so the next transfer can
// follow at once. Results cannot be held off by the receiver: it must take each
// strobe as it comes. Synchronous reset returns the controller to idle and drops
// any result in flight; at most 31 results are produced per value, the last one
// carrying the remaining cofactor.
`timescale 1ns / 1ps

module trial_division_factorizer #(
   parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_last
);
   import tdf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   tdf_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_factor (rsp_factor),
      .rsp_last   (rsp_last)
   );

   a_inner_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result outside an item");

   a_end_shows_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_last)
      else $error("item ended without a final result");

   a_busy_rises_on_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy raised without a transfer");

endmodule
